// File: src/mandelbrot_escape_time_defines.svh
// Assertion macros shared by the escape-time modules.
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

`ifndef SYNTHESIS
`define MBE_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");
`define MBE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");
`else
`define MBE_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define MBE_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// File: src/mbe_pkg.sv
// Types, constants and helper functions of the escape-time block.
package mbe_pkg;

    localparam int FRAC_BITS    = 28;
    localparam int PALETTE_SIZE = 16;
    localparam int COORD_W      = 9;
    localparam int CNT_W        = 16;
    localparam int VAL_W        = 32;
    localparam int STEP_W       = 31;
    localparam int PAL_W        = 4;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;

    localparam int PROD_W = 2 * VAL_W;
    localparam int SQ_W   = PROD_W - FRAC_BITS;
    localparam int XY_W   = SQ_W + 1;
    localparam int SUM_W  = SQ_W + 2;
    localparam int MAP_W  = COORD_W + STEP_W;
    localparam int WIDE_W = MAP_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = CFG_IDX_W'(3);

    localparam logic [CNT_W-1:0]         RST_MAX_ITER    = CNT_W'(100);
    localparam logic signed [VAL_W-1:0]  RST_ORIGIN_REAL = -VAL_W'(536870912);
    localparam logic signed [VAL_W-1:0]  RST_ORIGIN_IMAG = -VAL_W'(300647711);
    localparam logic [STEP_W-1:0]        RST_STEP_SIZE   = STEP_W'(1294961);

    localparam logic signed [XY_W-1:0] MAG_LIMIT = XY_W'(4) <<< FRAC_BITS;

    localparam logic signed [WIDE_W-1:0] SAT_HI =
        {{(WIDE_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_LO =
        {{(WIDE_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_MUL,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]        max_iter;
        logic signed [VAL_W-1:0] origin_real;
        logic signed [VAL_W-1:0] origin_imag;
        logic [STEP_W-1:0]       step_size;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic map;
        logic mul;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic at_max;
        logic over;
        logic out_free;
    } t_dp_sts;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[VAL_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/mbe_cfg_regs.sv
// Configuration register file of the escape-time block.
module mbe_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mbe_pkg::t_cfg                 o_cfg
);
    import mbe_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iter    <= RST_MAX_ITER;
            r_cfg.origin_real <= RST_ORIGIN_REAL;
            r_cfg.origin_imag <= RST_ORIGIN_IMAG;
            r_cfg.step_size   <= RST_STEP_SIZE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_ITER:    r_cfg.max_iter    <= i_cfg_data[CNT_W-1:0];
                CFG_ORIGIN_REAL: r_cfg.origin_real <= $signed(i_cfg_data[VAL_W-1:0]);
                CFG_ORIGIN_IMAG: r_cfg.origin_imag <= $signed(i_cfg_data[VAL_W-1:0]);
                CFG_STEP_SIZE:   r_cfg.step_size   <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: src/mbe_datapath.sv
// Datapath: point mapping, iteration arithmetic and output register.
`include "mandelbrot_escape_time_defines.svh"

module mbe_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbe_pkg::t_cfg               i_cfg,
    input  mbe_pkg::t_dp_cmd            i_cmd,
    output mbe_pkg::t_dp_sts            o_sts,
    input  logic [mbe_pkg::COORD_W-1:0] i_pixel_col,
    input  logic [mbe_pkg::COORD_W-1:0] i_pixel_row,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mbe_pkg::COORD_W-1:0] o_out_col,
    output logic [mbe_pkg::COORD_W-1:0] o_out_row,
    output logic [mbe_pkg::CNT_W-1:0]   o_iter_count,
    output logic [mbe_pkg::PAL_W-1:0]   o_palette_index,
    output logic                        o_escaped
);
    import mbe_pkg::*;

    logic [COORD_W-1:0]       r_col;
    logic [COORD_W-1:0]       r_row;
    logic [MAP_W-1:0]         r_map_re;
    logic [MAP_W-1:0]         r_map_im;
    logic signed [VAL_W-1:0]  r_cr;
    logic signed [VAL_W-1:0]  r_ci;
    logic signed [VAL_W-1:0]  r_x;
    logic signed [VAL_W-1:0]  r_y;
    logic signed [PROD_W-1:0] r_xx;
    logic signed [PROD_W-1:0] r_yy;
    logic signed [PROD_W-1:0] r_xy;
    logic [CNT_W-1:0]         r_count;
    logic                     r_out_valid;
    logic [COORD_W-1:0]       r_out_col;
    logic [COORD_W-1:0]       r_out_row;
    logic [CNT_W-1:0]         r_out_count;
    logic [PAL_W-1:0]         r_out_pal;
    logic                     r_out_esc;
    logic                     n_out_valid;

    logic signed [SQ_W-1:0]   w_x2;
    logic signed [SQ_W-1:0]   w_y2;
    logic signed [XY_W-1:0]   w_xy2;
    logic signed [XY_W-1:0]   w_mag;
    logic signed [SUM_W-1:0]  w_nx;
    logic signed [SUM_W-1:0]  w_ny;
    logic signed [WIDE_W-1:0] w_cr_sum;
    logic signed [WIDE_W-1:0] w_ci_sum;

    assign w_x2  = $signed(r_xx[PROD_W-1:FRAC_BITS]);
    assign w_y2  = $signed(r_yy[PROD_W-1:FRAC_BITS]);
    assign w_xy2 = $signed(r_xy[PROD_W-1:FRAC_BITS-1]);
    assign w_mag = XY_W'(w_x2) + XY_W'(w_y2);
    assign w_nx  = SUM_W'(w_x2) - SUM_W'(w_y2) + SUM_W'(r_cr);
    assign w_ny  = SUM_W'(w_xy2) + SUM_W'(r_ci);

    assign w_cr_sum = WIDE_W'(i_cfg.origin_real) + $signed({2'b00, r_map_re});
    assign w_ci_sum = WIDE_W'(i_cfg.origin_imag) + $signed({2'b00, r_map_im});

    assign o_sts.at_max   = (r_count >= i_cfg.max_iter);
    assign o_sts.over     = (w_mag > MAG_LIMIT);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col    <= i_pixel_col;
            r_row    <= i_pixel_row;
            r_map_re <= MAP_W'(i_pixel_col) * MAP_W'(i_cfg.step_size);
            r_map_im <= MAP_W'(i_pixel_row) * MAP_W'(i_cfg.step_size);
        end
        if (i_cmd.map) begin
            r_cr    <= sat32(w_cr_sum);
            r_ci    <= sat32(w_ci_sum);
            r_x     <= '0;
            r_y     <= '0;
            r_count <= '0;
        end
        if (i_cmd.mul) begin
            r_xx <= PROD_W'(r_x) * PROD_W'(r_x);
            r_yy <= PROD_W'(r_y) * PROD_W'(r_y);
            r_xy <= PROD_W'(r_x) * PROD_W'(r_y);
        end
        if (i_cmd.step) begin
            r_x     <= sat32(WIDE_W'(w_nx));
            r_y     <= sat32(WIDE_W'(w_ny));
            r_count <= r_count + CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_count <= r_count;
            r_out_pal   <= PAL_W'(r_count % CNT_W'(PALETTE_SIZE));
            r_out_esc   <= !o_sts.at_max;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_col       = r_out_col;
    assign o_out_row       = r_out_row;
    assign o_iter_count    = r_out_count;
    assign o_palette_index = r_out_pal;
    assign o_escaped       = r_out_esc;

    `MBE_ASSERT_IMPLIES(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !r_out_valid || i_out_ready)
    `MBE_ASSERT_IMPLIES(a_step_inside, i_clk, i_rst_n, i_cmd.step, !o_sts.at_max && !o_sts.over)
    `MBE_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_cmd.step, r_count == $past(r_count) + CNT_W'(1))

endmodule

// File: src/mbe_ctrl.sv
// Controller state machine sequencing mapping, iteration and result hand-off.
`include "mandelbrot_escape_time_defines.svh"

module mbe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mbe_pkg::t_dp_sts  i_sts,
    output mbe_pkg::t_dp_cmd  o_cmd
);
    import mbe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MAP;
                end
            end
            S_MAP:  n_state = S_MUL;
            S_MUL:  n_state = S_STEP;
            S_STEP: begin
                if (i_sts.at_max || i_sts.over) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MAP:  o_cmd.map = 1'b1;
            S_MUL:  o_cmd.mul = 1'b1;
            S_STEP: o_cmd.step = !i_sts.at_max && !i_sts.over;
            S_DONE: o_cmd.emit = i_sts.out_free;
            default: begin
            end
        endcase
    end

    `MBE_ASSERT_NEXT(a_load_map, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_MAP)
    `MBE_ASSERT_IMPLIES(a_ready_idle, i_clk, i_rst_n, o_in_ready, !o_cmd.emit && !o_cmd.step)
    `MBE_ASSERT_NEXT(a_emit_idle, i_clk, i_rst_n, o_cmd.emit, r_state == S_IDLE)

endmodule

// File: src/mandelbrot_escape_time.sv
// Top level of the escape-time evaluator: config registers, controller, datapath.
//
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_pixel_col, i_pixel_row
// result    out        o_out_valid / i_out_ready    o_out_col, o_out_row, o_iter_count,
//                                                   o_palette_index, o_escaped
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// After acceptance a pixel is mapped, then iterates through the multiply and update
// states of the controller loop (S_MUL, S_STEP) until its result is made valid.
// One pixel is in flight at a time; the next is accepted while a result waits.
// A stalled result holds the datapath in its final state until taken.
// Reset is synchronous, active low, and restores the register defaults.
module mandelbrot_escape_time (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [mbe_pkg::COORD_W-1:0]    i_pixel_col,
    input  logic [mbe_pkg::COORD_W-1:0]    i_pixel_row,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mbe_pkg::COORD_W-1:0]    o_out_col,
    output logic [mbe_pkg::COORD_W-1:0]    o_out_row,
    output logic [mbe_pkg::CNT_W-1:0]      o_iter_count,
    output logic [mbe_pkg::PAL_W-1:0]      o_palette_index,
    output logic                           o_escaped,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mbe_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mbe_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mbe_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_pixel_col     (i_pixel_col),
        .i_pixel_row     (i_pixel_row),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_col       (o_out_col),
        .o_out_row       (o_out_row),
        .o_iter_count    (o_iter_count),
        .o_palette_index (o_palette_index),
        .o_escaped       (o_escaped)
    );

endmodule
